// ===== hdl/sbpf_pkg.sv =====
// Package: constants and types for the servo bus packet framer.
`timescale 1ns / 1ps

package sbpf_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t HDR_BYTE = 8'hFF;
    localparam byte_t WR_LEN   = 8'h09;
    localparam byte_t WR_INSTR = 8'h03;
    localparam byte_t WR_ADDR  = 8'h2A;
    localparam byte_t RD_LEN   = 8'h04;
    localparam byte_t RD_INSTR = 8'h02;

    localparam logic signed [15:0] POS_MAX = 16'sd1000;

    // Bytes held ahead of the checksum in the longest frame.
    localparam int FRAME_BYTES = 12;
    localparam int IDX_W       = 4;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t WR_LAST_IDX = 4'd12;
    localparam idx_t RD_LAST_IDX = 4'd7;
    localparam idx_t SUM_START   = 4'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

endpackage

// ===== hdl/servo_bus_packet_framer.sv =====
// Servo bus instruction framer: one request item in, one frame of bytes out.
//
// Channel  Dir  Width       Contents
// s_axis   in   72 + 1      request: tdata fields, tuser = cmd
// m_axis   out  8 + 1       frame byte: tdata = tx_byte, tlast = last_byte
//
// One byte per cycle while m_axis is not stalled; a write frame has 13 bytes, a read frame 8,
// sent through the single byte output register.
// The next request is accepted in the cycle the checksum byte is loaded into the output
// register, so frames follow back to back.
// The checksum accumulates over the bytes from the servo id on as they are sent.
// Reset clears the busy flag, index and output valid; a stall on m_axis holds
// the output register and the frame.
`timescale 1ns / 1ps

module servo_bus_packet_framer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] servo_id, [23:8] target_position, [39:24] move_time,
    // [55:40] move_speed, [63:56] read_address, [71:64] read_length
    input  logic [71:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]  m_axis_tdata,
    // last_byte
    output logic        m_axis_tlast
);

    sbpf_pkg::byte_t frame_reg [sbpf_pkg::FRAME_BYTES];
    sbpf_pkg::byte_t frame_next [sbpf_pkg::FRAME_BYTES];
    sbpf_pkg::idx_t  idx_reg, idx_next;
    sbpf_pkg::idx_t  last_idx_reg, last_idx_next;
    sbpf_pkg::byte_t sum_reg, sum_next;
    logic            busy_reg, busy_next;

    logic            out_valid_reg, out_valid_next;
    sbpf_pkg::byte_t out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;

    logic            advance;
    logic            at_last;
    logic            accept;
    sbpf_pkg::byte_t cur_byte;

    logic signed [15:0] pos_in;
    logic        [15:0] pos_clamped;
    logic        [7:0]  in_id;
    logic        [15:0] in_time;
    logic        [15:0] in_speed;
    logic        [7:0]  in_addr;
    logic        [7:0]  in_len;

    assign in_id    = s_axis_tdata[7:0];
    assign pos_in   = s_axis_tdata[23:8];
    assign in_time  = s_axis_tdata[39:24];
    assign in_speed = s_axis_tdata[55:40];
    assign in_addr  = s_axis_tdata[63:56];
    assign in_len   = s_axis_tdata[71:64];

    always_comb
    begin
        if (pos_in < 16'sd0)
        begin
            pos_clamped = 16'd0;
        end
        else if (pos_in > sbpf_pkg::POS_MAX)
        begin
            pos_clamped = 16'(sbpf_pkg::POS_MAX);
        end
        else
        begin
            pos_clamped = 16'(pos_in);
        end
    end

    assign advance = busy_reg && (!out_valid_reg || m_axis_tready);
    assign at_last = (idx_reg == last_idx_reg);
    assign s_axis_tready = !busy_reg || (advance && at_last);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (at_last)
        begin
            cur_byte = ~sum_reg;
        end
        else
        begin
            cur_byte = frame_reg[idx_reg];
        end
    end

    always_comb
    begin
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        sum_next       = sum_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_byte;
            out_last_next  = at_last;
            idx_next       = idx_reg + 1'b1;
            if (idx_reg >= sbpf_pkg::SUM_START)
            begin
                sum_next = sum_reg + cur_byte;
            end
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end

        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            sum_next  = '0;
            for (int i = 0; i < sbpf_pkg::FRAME_BYTES; i++)
            begin
                frame_next[i] = 8'h00;
            end
            frame_next[0] = sbpf_pkg::HDR_BYTE;
            frame_next[1] = sbpf_pkg::HDR_BYTE;
            frame_next[2] = in_id;
            if (s_axis_tuser == sbpf_pkg::CMD_READ)
            begin
                last_idx_next = sbpf_pkg::RD_LAST_IDX;
                frame_next[3] = sbpf_pkg::RD_LEN;
                frame_next[4] = sbpf_pkg::RD_INSTR;
                frame_next[5] = in_addr;
                frame_next[6] = in_len;
            end
            else
            begin
                last_idx_next  = sbpf_pkg::WR_LAST_IDX;
                frame_next[3]  = sbpf_pkg::WR_LEN;
                frame_next[4]  = sbpf_pkg::WR_INSTR;
                frame_next[5]  = sbpf_pkg::WR_ADDR;
                frame_next[6]  = pos_clamped[15:8];
                frame_next[7]  = pos_clamped[7:0];
                frame_next[8]  = in_time[15:8];
                frame_next[9]  = in_time[7:0];
                frame_next[10] = in_speed[15:8];
                frame_next[11] = in_speed[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        last_idx_reg <= last_idx_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && idx_reg == '0))
        else $error("accepted item did not start a frame");

    a_last_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && at_last) |=> (out_valid_reg && out_last_reg))
        else $error("checksum byte not flagged last");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_idx_reg))
        else $error("byte index past end of frame");

    a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !at_last) |-> !s_axis_tready)
        else $error("ready raised in the middle of a frame");
`endif

endmodule

// ===== test/servo_bus_packet_framer_tb.sv =====
// Testbench: random and directed requests against a servo bus frame scoreboard.
`timescale 1ns / 1ps

module servo_bus_packet_framer_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYC   = 400;
    localparam int ITEMS_PER_PHASE = 45;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         servo_id;
        logic signed [15:0] target_position;
        logic [15:0]        move_time;
        logic [15:0]        move_speed;
        logic [7:0]         read_address;
        logic [7:0]         read_length;
    } request_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } frame_byte_t;

    class frame_scoreboard;
        frame_byte_t expected_bytes[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Build the frame for an accepted request and queue its bytes.
        function void note_request(request_t r);
            sbpf_pkg::byte_t    frame[$];
            logic signed [15:0] pos;
            logic [15:0]        clamped;
            sbpf_pkg::byte_t    sum;
            frame_byte_t        fb;
            frame = '{sbpf_pkg::HDR_BYTE, sbpf_pkg::HDR_BYTE, r.servo_id};
            if (r.cmd == sbpf_pkg::CMD_WRITE)
            begin
                pos = r.target_position;
                if (pos < 16'sd0)
                    clamped = 16'd0;
                else if (pos > sbpf_pkg::POS_MAX)
                    clamped = sbpf_pkg::POS_MAX;
                else
                    clamped = pos;
                frame.push_back(sbpf_pkg::WR_LEN);
                frame.push_back(sbpf_pkg::WR_INSTR);
                frame.push_back(sbpf_pkg::WR_ADDR);
                frame.push_back(clamped[15:8]);
                frame.push_back(clamped[7:0]);
                frame.push_back(r.move_time[15:8]);
                frame.push_back(r.move_time[7:0]);
                frame.push_back(r.move_speed[15:8]);
                frame.push_back(r.move_speed[7:0]);
            end
            else
            begin
                frame.push_back(sbpf_pkg::RD_LEN);
                frame.push_back(sbpf_pkg::RD_INSTR);
                frame.push_back(r.read_address);
                frame.push_back(r.read_length);
            end
            sum = 8'd0;
            for (int k = 2; k < frame.size(); k++)
                sum += frame[k];
            foreach (frame[k])
            begin
                fb.tx_byte   = frame[k];
                fb.last_byte = 1'b0;
                expected_bytes.push_back(fb);
            end
            fb.tx_byte   = ~sum;
            fb.last_byte = 1'b1;
            expected_bytes.push_back(fb);
        endfunction

        function void check_byte(logic [7:0] tx_byte, logic last_byte);
            frame_byte_t exp_b;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected item: tx_byte %02h last_byte %0b", tx_byte, last_byte);
                errors++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (tx_byte !== exp_b.tx_byte)
            begin
                $error("tx_byte: expected %02h, got %02h", exp_b.tx_byte, tx_byte);
                errors++;
            end
            if (last_byte !== exp_b.last_byte)
            begin
                $error("last_byte: expected %0b, got %0b", exp_b.last_byte, last_byte);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    frame_scoreboard sb;
    int              send_idle_pct;
    int              rx_stall_pct;
    logic            hold_req;
    logic            hold_seen = 1'b0;
    int              rx_hold = 0;
    int              idle_cycles = 0;

    servo_bus_packet_framer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic request_t make_req(logic cmd, logic [7:0] id, logic signed [15:0] pos,
                                          logic [15:0] tm, logic [15:0] sp,
                                          logic [7:0] addr, logic [7:0] len);
        request_t r;
        r.cmd             = cmd;
        r.servo_id        = id;
        r.target_position = pos;
        r.move_time       = tm;
        r.move_speed      = sp;
        r.read_address    = addr;
        r.read_length     = len;
        return r;
    endfunction

    function automatic request_t random_req();
        request_t r;
        r.cmd      = 1'($urandom_range(1));
        r.servo_id = 8'($urandom);
        case ($urandom_range(2))
            0:       r.target_position = 16'($urandom);
            1:       r.target_position = 16'($urandom_range(1100) - 50);
            default: r.target_position = 16'($urandom_range(1000));
        endcase
        r.move_time    = 16'($urandom);
        r.move_speed   = 16'($urandom);
        r.read_address = 8'($urandom);
        r.read_length  = 8'($urandom);
        return r;
    endfunction

    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {r.read_length, r.read_address, r.move_speed, r.move_time,
                          r.target_position, r.servo_id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        repeat (count)
            send_request(random_req());
        wait_drained();
    endtask

    // Receiver: random stalls plus a single long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen = 1'b1;
            rx_hold   = HOLD_OFF_CYC;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_byte(m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("servo_bus_packet_framer regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sbpf_pkg::CMD_WRITE;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: clamp edges, field extremes, reserved ids, checksum wrap
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd0,   -16'sd32768, 16'h0000, 16'h0000,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd1,   -16'sd1,     16'hFFFF, 16'hFFFF,
                              8'hFF, 8'hFF));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd2,   16'sd0,      16'h1234, 16'h5678,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd3,   16'sd1,      16'h00FF, 16'hFF00,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd100, 16'sd999,    16'h8000, 16'h0001,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd253, 16'sd1000,   16'hFFFF, 16'hFFFF,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd254, 16'sd1001,   16'hFFFF, 16'hFFFF,
                              8'hFF, 8'hFF));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd255, 16'sd32767,  16'hFFFF, 16'hFFFF,
                              8'hA5, 8'h5A));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd255, 16'sd256,    16'h0100, 16'h00FF,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd0,   16'sd0,      16'h0000, 16'h0000,
                              8'h00, 8'h00));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd253, -16'sd1,     16'hFFFF, 16'hFFFF,
                              8'hFF, 8'hFF));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd254, 16'sd500,    16'hABCD, 16'h1357,
                              8'h38, 8'h02));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd255, -16'sd32768, 16'h0000, 16'hFFFF,
                              8'hFF, 8'hFF));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd1,   16'sd32767,  16'hFFFF, 16'h0000,
                              8'h00, 8'hFF));
        send_request(make_req(sbpf_pkg::CMD_READ,  8'd128, 16'sd1000,   16'h5555, 16'hAAAA,
                              8'h80, 8'h01));
        send_request(make_req(sbpf_pkg::CMD_WRITE, 8'd128, -16'sd1000,  16'hAAAA, 16'h5555,
                              8'h80, 8'h01));
        wait_drained();

        // receiver holds off while the sender keeps offering, so the input stalls
        hold_req = 1'b1;
        run_phase(0, 0, ITEMS_PER_PHASE);
        run_phase(63, 0, ITEMS_PER_PHASE);
        run_phase(0, 63, ITEMS_PER_PHASE);
        run_phase(6, 6, ITEMS_PER_PHASE);

        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("servo_bus_packet_framer regression: pass");
        else
            $display("servo_bus_packet_framer regression: fail");
        $finish;
    end

endmodule
